>>> design/deq_pkg.sv
package deq_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 10;
    localparam int WORD_W   = 32;
    localparam int ERR_W    = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_READ_AT    = 3'd2,
        OP_WRITE_AT   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_EMPTY = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MEM,
        ST_RESP
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic addr;
        logic mem;
        logic resp;
    } t_cmd;

endpackage

>>> design/deq_ctrl.sv
module deq_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    output deq_pkg::t_cmd o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = deq_pkg::ST_ADDR;
                end
            end
            deq_pkg::ST_ADDR: n_state = deq_pkg::ST_MEM;
            deq_pkg::ST_MEM:  n_state = deq_pkg::ST_RESP;
            deq_pkg::ST_RESP: n_state = deq_pkg::ST_IDLE;
            default:          n_state = deq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            deq_pkg::ST_ADDR: o_cmd.addr = 1'b1;
            deq_pkg::ST_MEM:  o_cmd.mem  = 1'b1;
            deq_pkg::ST_RESP: o_cmd.resp = 1'b1;
            default:          busy       = 1'b1;
        endcase
    end

endmodule

>>> design/deq_dp.sv
module deq_dp #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  deq_pkg::t_cmd                 i_cmd,
    input  logic [deq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [deq_pkg::INDEX_W-1:0]   i_elem_index,
    input  logic [deq_pkg::WORD_W-1:0]    i_data_in,
    output logic [deq_pkg::WORD_W-1:0]    o_read_value,
    output logic [deq_pkg::ERR_W-1:0]     o_error_code,
    output logic [deq_pkg::COUNT_W-1:0]   o_element_count,
    output logic                          o_is_empty
);

    localparam int PW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;
    localparam int EXW  = (DATA_WIDTH > deq_pkg::WORD_W) ? DATA_WIDTH : deq_pkg::WORD_W;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    logic [deq_pkg::OPCODE_W-1:0] r_op;
    logic [deq_pkg::INDEX_W-1:0]  r_idx;
    logic [deq_pkg::WORD_W-1:0]   r_data;
    logic [PW-1:0]                r_addr;
    logic [PW-1:0]                n_addr;
    deq_pkg::t_err                r_err;
    deq_pkg::t_err                n_err;
    logic [PW-1:0]                r_front;
    logic [CW-1:0]                r_count;
    logic signed [DATA_WIDTH-1:0] r_rd;

    logic [PW-1:0]  offset;
    logic [PW:0]    slot_sum;
    logic [PW-1:0]  slot;
    logic           full;
    logic           empty;
    logic           in_range;
    logic           is_read;
    logic           is_write;
    logic signed [EXW-1:0] rd_ext;

    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign in_range = (CMPW'(r_idx) < CMPW'(r_count));

    // ring slot of a logical position
    always_comb begin
        case (r_op)
            deq_pkg::OP_PUSH_BACK:  offset = PW'(r_count);
            deq_pkg::OP_READ_BACK:  offset = PW'(r_count - CW'(1));
            deq_pkg::OP_READ_AT,
            deq_pkg::OP_WRITE_AT:   offset = PW'(r_idx);
            default:                offset = '0;
        endcase
        slot_sum = {1'b0, r_front} + {1'b0, offset};
        if (slot_sum >= (PW+1)'(CAPACITY)) begin
            slot = PW'(slot_sum - (PW+1)'(CAPACITY));
        end else begin
            slot = PW'(slot_sum);
        end
    end

    always_comb begin
        n_err  = deq_pkg::ERR_OK;
        n_addr = slot;
        case (r_op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_err = deq_pkg::ERR_FULL;
                end
                n_addr = (r_front == '0) ? PW'(CAPACITY - 1) : r_front - PW'(1);
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_err = deq_pkg::ERR_FULL;
                end
            end
            deq_pkg::OP_READ_AT,
            deq_pkg::OP_WRITE_AT: begin
                if (!in_range) begin
                    n_err = deq_pkg::ERR_RANGE;
                end
            end
            deq_pkg::OP_READ_FRONT,
            deq_pkg::OP_READ_BACK: begin
                if (empty) begin
                    n_err = deq_pkg::ERR_EMPTY;
                end
            end
            default: n_err = deq_pkg::ERR_OK;
        endcase
    end

    assign is_read  = (r_op == deq_pkg::OP_READ_AT) || (r_op == deq_pkg::OP_READ_FRONT)
                   || (r_op == deq_pkg::OP_READ_BACK);
    assign is_write = (r_op == deq_pkg::OP_PUSH_FRONT) || (r_op == deq_pkg::OP_PUSH_BACK)
                   || (r_op == deq_pkg::OP_WRITE_AT);

    // capture word and access plan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_idx  <= i_elem_index;
            r_data <= i_data_in;
        end
        if (i_cmd.addr) begin
            r_addr <= n_addr;
            r_err  <= n_err;
        end
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem && is_write && (r_err == deq_pkg::ERR_OK)) begin
            r_mem[r_addr] <= DATA_WIDTH'(r_data);
        end
        if (i_cmd.mem && is_read) begin
            r_rd <= r_mem[r_addr];
        end
    end

    // ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.mem && (r_err == deq_pkg::ERR_OK)) begin
            if (r_op == deq_pkg::OP_PUSH_FRONT) begin
                r_front <= r_addr;
                r_count <= r_count + CW'(1);
            end else if (r_op == deq_pkg::OP_PUSH_BACK) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign rd_ext = EXW'(r_rd);

    assign o_read_value    = (is_read && (r_err == deq_pkg::ERR_OK))
                           ? rd_ext[deq_pkg::WORD_W-1:0] : '0;
    assign o_error_code    = r_err;
    assign o_element_count = deq_pkg::COUNT_W'(r_count);
    assign o_is_empty      = empty;

endmodule

>>> design/double_ended_queue_indexed.sv
// Bounded double-ended queue of signed words with indexed access. Pulse start
// with an opcode (push front, push back, read at index, write at index, read
// front, read back) while busy is low; the word is taken at that edge. Exactly
// one result follows: o_valid is high for one cycle, the result cycle, and the
// result is taken at the edge that ends it. It carries the read value, an error
// code, the element count after the operation and an empty flag. The receiver
// cannot stall, so capture the result in the o_valid cycle. busy stays high
// from the accepting edge through the result cycle, so no new word is taken
// until the block is idle again. Each word passes through these steps in order:
// the ring slot is formed (front pointer plus offset, wrapped), the single-port
// element memory, whose read data is registered, is accessed, the result is
// presented, and the next word is taken in the idle state. Failed pushes,
// reads of an empty queue and out-of-range indexes are flagged and change
// nothing.
module double_ended_queue_indexed #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [deq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [deq_pkg::INDEX_W-1:0]   i_elem_index,
    input  logic [deq_pkg::WORD_W-1:0]    i_data_in,
    output logic                          busy,
    output logic                          o_valid,
    output logic [deq_pkg::WORD_W-1:0]    o_read_value,
    output logic [deq_pkg::ERR_W-1:0]     o_error_code,
    output logic [deq_pkg::COUNT_W-1:0]   o_element_count,
    output logic                          o_is_empty
);

    deq_pkg::t_cmd cmd;

    // sequence each word through slot, memory and result phases
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // ring pointers, element memory and result formation
    deq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_elem_index    (i_elem_index),
        .i_data_in       (i_data_in),
        .o_read_value    (o_read_value),
        .o_error_code    (o_error_code),
        .o_element_count (o_element_count),
        .o_is_empty      (o_is_empty)
    );

    // result strobe marks the result phase
    assign o_valid = cmd.resp;

endmodule

>>> design/deq_chk.sv
module deq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [deq_pkg::WORD_W-1:0]    o_read_value,
    input logic [deq_pkg::ERR_W-1:0]     o_error_code,
    input logic [deq_pkg::COUNT_W-1:0]   o_element_count,
    input logic                          o_is_empty
);

    // every accepted word gets its result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing after accepted word");

    // a result is only shown while the word is still in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside busy window");

    // failed operations return a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != deq_pkg::ERR_OK)) |-> (o_read_value == '0))
        else $error("nonzero read value on failed operation");

    // empty error only when the queue is empty
    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code == deq_pkg::ERR_EMPTY)) |-> (o_is_empty && !$past(o_valid)))
        else $error("empty error on nonempty queue");

    // the empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_element_count == '0))
        else $error("empty flag with nonzero count");

endmodule

bind double_ended_queue_indexed deq_chk u_deq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_read_value    (o_read_value),
    .o_error_code    (o_error_code),
    .o_element_count (o_element_count),
    .o_is_empty      (o_is_empty)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DEQ_DEPTH      = 1024;
    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int RESULT_LATENCY = 4;
    localparam int RANDOM_WORDS   = 1327;
    localparam int DRAIN_LIMIT    = 100;
    localparam int MAX_GAP        = 6;

    // Opcodes the block ignores; they still answer with one result.
    localparam logic [deq_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [deq_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    // Shadow deque: mirrors the ring, the front slot and the element count,
    // and queues the result each accepted word must produce.
    class deque_scoreboard;
        typedef struct {
            logic [deq_pkg::WORD_W-1:0]  read_value;
            deq_pkg::t_err               error_code;
            logic [deq_pkg::COUNT_W-1:0] element_count;
            logic                        is_empty;
        } t_outcome;

        logic [deq_pkg::WORD_W-1:0]  ring [DEQ_DEPTH];
        logic [deq_pkg::INDEX_W-1:0] front_slot;
        logic [deq_pkg::COUNT_W-1:0] live_count;
        t_outcome                    expected_results [$];
        int unsigned                 words_noted;
        int unsigned                 results_checked;
        int unsigned                 mismatches;
        int unsigned                 outcome_tally [4];

        function new();
            front_slot = '0;
            live_count = '0;
            words_noted = 0;
            results_checked = 0;
            mismatches = 0;
            foreach (outcome_tally[k]) outcome_tally[k] = 0;
        endfunction

        // Apply one accepted word to the shadow deque and queue its result.
        function void note_word(input logic [deq_pkg::OPCODE_W-1:0] op,
                                input logic [deq_pkg::INDEX_W-1:0]  idx,
                                input logic [deq_pkg::WORD_W-1:0]   data);
            t_outcome                    o;
            logic [deq_pkg::INDEX_W-1:0] slot;
            o.read_value = '0;
            o.error_code = deq_pkg::ERR_OK;
            case (op)
                deq_pkg::OP_PUSH_FRONT: begin
                    if (live_count >= DEQ_DEPTH) begin
                        o.error_code = deq_pkg::ERR_FULL;
                    end else begin
                        front_slot = front_slot - 1'b1;
                        ring[front_slot] = data;
                        live_count++;
                    end
                end
                deq_pkg::OP_PUSH_BACK: begin
                    if (live_count >= DEQ_DEPTH) begin
                        o.error_code = deq_pkg::ERR_FULL;
                    end else begin
                        slot = front_slot + live_count[deq_pkg::INDEX_W-1:0];
                        ring[slot] = data;
                        live_count++;
                    end
                end
                deq_pkg::OP_READ_AT, deq_pkg::OP_WRITE_AT: begin
                    if ({1'b0, idx} >= live_count) begin
                        o.error_code = deq_pkg::ERR_RANGE;
                    end else begin
                        slot = front_slot + idx;
                        if (op == deq_pkg::OP_READ_AT) o.read_value = ring[slot];
                        else ring[slot] = data;
                    end
                end
                deq_pkg::OP_READ_FRONT, deq_pkg::OP_READ_BACK: begin
                    if (live_count == 0) begin
                        o.error_code = deq_pkg::ERR_EMPTY;
                    end else begin
                        slot = (op == deq_pkg::OP_READ_FRONT) ? front_slot
                             : front_slot + live_count[deq_pkg::INDEX_W-1:0] - 1'b1;
                        o.read_value = ring[slot];
                    end
                end
                default: ;
            endcase
            o.element_count = live_count;
            o.is_empty = (live_count == 0);
            outcome_tally[o.error_code]++;
            words_noted++;
            expected_results.insert(expected_results.size(), o);
        endfunction

        // Compare one result with the oldest pending outcome, field by field.
        function void check_result(input logic [deq_pkg::WORD_W-1:0]  read_value,
                                   input logic [deq_pkg::ERR_W-1:0]   error_code,
                                   input logic [deq_pkg::COUNT_W-1:0] element_count,
                                   input logic                        is_empty);
            t_outcome e;
            if (expected_results.size() == 0) begin
                $error("result with no word pending: read_value %h error_code %0d",
                       read_value, error_code);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            results_checked++;
            if (read_value !== e.read_value) begin
                $error("read_value: expected %h, got %h", e.read_value, read_value);
                mismatches++;
            end
            if (error_code !== e.error_code) begin
                $error("error_code: expected %0d, got %0d", e.error_code, error_code);
                mismatches++;
            end
            if (element_count !== e.element_count) begin
                $error("element_count: expected %0d, got %0d",
                       e.element_count, element_count);
                mismatches++;
            end
            if (is_empty !== e.is_empty) begin
                $error("is_empty: expected %0b, got %0b", e.is_empty, is_empty);
                mismatches++;
            end
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic [deq_pkg::OPCODE_W-1:0]  i_opcode     = '0;
    logic [deq_pkg::INDEX_W-1:0]   i_elem_index = '0;
    logic [deq_pkg::WORD_W-1:0]    i_data_in    = '0;
    logic                          busy;
    logic                          o_valid;
    logic [deq_pkg::WORD_W-1:0]    o_read_value;
    logic [deq_pkg::ERR_W-1:0]     o_error_code;
    logic [deq_pkg::COUNT_W-1:0]   o_element_count;
    logic                          o_is_empty;

    deque_scoreboard sb = new();

    // Chance in percent that the sender pauses before the next word.
    int unsigned gap_pct = 38;
    int unsigned directed_words;

    double_ended_queue_indexed u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_opcode        (i_opcode),
        .i_elem_index    (i_elem_index),
        .i_data_in       (i_data_in),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_read_value    (o_read_value),
        .o_error_code    (o_error_code),
        .o_element_count (o_element_count),
        .o_is_empty      (o_is_empty)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Take each result in its strobe cycle; values read here are the ones
    // held before this edge, so the order of processes does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            sb.check_result(o_read_value, o_error_code, o_element_count, o_is_empty);
        end
    end

    // Offer one word and hold it until the block takes it. Start stays high
    // across back-to-back words; drop it only when a pause is drawn.
    task automatic send_word(input logic [deq_pkg::OPCODE_W-1:0] op,
                             input logic [deq_pkg::INDEX_W-1:0]  idx,
                             input logic [deq_pkg::WORD_W-1:0]   data);
        int unsigned gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, MAX_GAP);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_elem_index <= idx;
        i_data_in    <= data;
        // The word is taken at the first edge that sees busy low.
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_word(op, idx, data);
    endtask

    // Draw one random word. While the deque fills, most words are pushes so
    // the run reaches the full state; once full, favor reads and writes
    // and keep a few pushes to hit the full refusal. Indexes mostly land
    // on live elements, with a share spread over the whole field.
    task automatic send_random_word();
        logic [deq_pkg::OPCODE_W-1:0] op;
        logic [deq_pkg::INDEX_W-1:0]  idx;
        int unsigned                  push_share;
        int unsigned                  pick;
        push_share = (sb.live_count == DEQ_DEPTH) ? 15 : 84;
        pick = $urandom_range(0, 99);
        if (pick < push_share) begin
            op = (pick % 2 != 0) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = deq_pkg::OP_READ_AT;
            else if (pick < 70) op = deq_pkg::OP_WRITE_AT;
            else if (pick < 82) op = deq_pkg::OP_READ_FRONT;
            else if (pick < 94) op = deq_pkg::OP_READ_BACK;
            else if (pick < 97) op = OP_UNUSED_LO;
            else                op = OP_UNUSED_HI;
        end
        if (sb.live_count != 0 && $urandom_range(0, 99) < 88) begin
            idx = deq_pkg::INDEX_W'($urandom_range(0, sb.live_count - 1));
        end else begin
            idx = deq_pkg::INDEX_W'($urandom_range(0, DEQ_DEPTH - 1));
        end
        send_word(op, idx, $urandom());
    endtask

    // Stop a hung run; far beyond the slowest correct run of this length.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned drain;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty deque: every read and indexed write must be refused.
        send_word(deq_pkg::OP_READ_FRONT, '0, '0);
        send_word(deq_pkg::OP_READ_BACK,  '0, '0);
        send_word(deq_pkg::OP_READ_AT,    '0, '0);
        send_word(deq_pkg::OP_WRITE_AT,   '0, 32'h1234_5678);
        send_word(deq_pkg::OP_READ_AT,    '1, '0);
        send_word(OP_UNUSED_LO,           '1, '1);
        send_word(OP_UNUSED_HI,           '0, '0);

        // Build front to back: FFFFFFFF, 80000000, 7FFFFFFF, 00000000.
        send_word(deq_pkg::OP_PUSH_BACK,  '0, 32'h7FFF_FFFF);
        send_word(deq_pkg::OP_PUSH_FRONT, '0, 32'h8000_0000);
        send_word(deq_pkg::OP_PUSH_BACK,  '1, 32'h0000_0000);
        send_word(deq_pkg::OP_PUSH_FRONT, '1, 32'hFFFF_FFFF);
        send_word(deq_pkg::OP_READ_FRONT, '0, '0);
        send_word(deq_pkg::OP_READ_BACK,  '0, '0);
        send_word(deq_pkg::OP_READ_AT,    10'd0, '0);
        send_word(deq_pkg::OP_READ_AT,    10'd3, '0);
        send_word(deq_pkg::OP_READ_AT,    10'd4, '0);
        send_word(deq_pkg::OP_READ_AT,    '1, '0);

        // Overwrite both ends, then try one past the back.
        send_word(deq_pkg::OP_WRITE_AT,   10'd0, 32'h5555_5555);
        send_word(deq_pkg::OP_WRITE_AT,   10'd3, 32'hAAAA_AAAA);
        send_word(deq_pkg::OP_WRITE_AT,   10'd4, 32'hDEAD_BEEF);
        send_word(deq_pkg::OP_READ_AT,    10'd0, '0);
        send_word(deq_pkg::OP_READ_AT,    10'd3, '0);
        send_word(OP_UNUSED_HI,           10'd2, '1);
        directed_words = sb.words_noted;

        // Random part in three stretches: sender pauses often, more often,
        // then not at all.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) gap_pct = 53;
            else if (n == 2 * RANDOM_WORDS / 3) gap_pct = 0;
            send_random_word();
        end
        start <= 1'b0;

        // Wait for the last results, then watch a while for strays.
        drain = 0;
        while (sb.expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d results never arrived", sb.expected_results.size());
            sb.mismatches++;
        end

        $display("Sent %0d words (%0d directed), compared %0d results; final depth %0d of %0d.",
                 sb.words_noted, directed_words, sb.results_checked,
                 sb.live_count, DEQ_DEPTH);
        $display("Outcomes: %0d ok, %0d index out of range, %0d full, %0d empty.",
                 sb.outcome_tally[deq_pkg::ERR_OK], sb.outcome_tally[deq_pkg::ERR_RANGE],
                 sb.outcome_tally[deq_pkg::ERR_FULL], sb.outcome_tally[deq_pkg::ERR_EMPTY]);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> double_ended_queue_indexed.f
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue_indexed.sv
design/deq_chk.sv
bench/testbench.sv
